FILE: src/hbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_pkg
// Shared types and constants for the histogram bucket counter.
// ----------------------------------------------------------------------------
package hbc_pkg;

    localparam int CMD_W     = 2;
    localparam int BUCKET_W  = 8;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int BIU_W     = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER   = 2'd0,
        CFG_UPPER   = 2'd1,
        CFG_BUCKETS = 2'd2,
        CFG_NONE    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WSTART,
        ST_WWAIT,
        ST_ISTART,
        ST_IWAIT,
        ST_ARD,
        ST_AUPD,
        ST_RRD,
        ST_RDAT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic width_start;
        logic width_load;
        logic idx_start;
        logic idx_load;
        logic mem_read;
        logic mem_update;
        logic res_read;
        logic out_load;
        logic clr_start;
        logic clr_step;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t in_cmd;
        cmd_t cmd;
        logic width_dirty;
        logic div_done;
        logic clr_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: src/hbc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hbc_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W:0]       rem_sh;
    logic [W:0]       rem_sub;
    logic             q_bit;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        q_bit   = !rem_sub[W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= q_bit ? rem_sub[W-1:0] : rem_sh[W-1:0];
            quo_reg <= {quo_reg[W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/hbc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_datapath
// Configuration registers, bucket width, count memory, binning arithmetic
// and the output register.
// ----------------------------------------------------------------------------
module hbc_datapath #(
    parameter int MAX_BUCKETS = 256,
    parameter int SAMPLE_BITS = 32,
    parameter int COUNT_BITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hbc_pkg::CFG_W-1:0]     cfg_data,
    input  logic [hbc_pkg::CMD_W-1:0]     in_cmd,
    input  logic [SAMPLE_BITS-1:0]        in_sample,
    input  logic [hbc_pkg::BUCKET_W-1:0]  in_select,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [hbc_pkg::BUCKET_W-1:0]  out_bucket,
    output logic [COUNT_BITS-1:0]         out_count,
    input  hbc_pkg::dp_cmd_t              ctl,
    output hbc_pkg::dp_status_t           sts
);

    localparam int IDX_W = $clog2(MAX_BUCKETS);
    localparam int ACT_W = $clog2(MAX_BUCKETS + 1);
    localparam int AW    = (ACT_W > hbc_pkg::BIU_W) ? ACT_W : hbc_pkg::BIU_W;
    localparam int DVW   = (SAMPLE_BITS > ACT_W) ? SAMPLE_BITS : ACT_W;
    localparam int SEL_W = (IDX_W > hbc_pkg::BUCKET_W) ? IDX_W : hbc_pkg::BUCKET_W;
    localparam int EXT_W = (SAMPLE_BITS > hbc_pkg::CFG_W) ? SAMPLE_BITS : hbc_pkg::CFG_W;
    localparam int DIF_W = SAMPLE_BITS + 1;

    logic [hbc_pkg::CFG_W-1:0]    lower_reg;
    logic [hbc_pkg::CFG_W-1:0]    upper_reg;
    logic [hbc_pkg::BIU_W-1:0]    biu_reg;
    logic [SAMPLE_BITS-1:0]       width_reg;
    logic                         dirty_reg;
    hbc_pkg::cmd_t                cmd_reg;
    logic [SAMPLE_BITS-1:0]       sample_reg;
    logic                         sel_ok_reg;
    logic [IDX_W-1:0]             addr_reg;
    logic [IDX_W-1:0]             clr_reg;
    logic [hbc_pkg::BUCKET_W-1:0] res_bucket_reg;
    logic [COUNT_BITS-1:0]        res_count_reg;
    logic [COUNT_BITS-1:0]        rdata_reg;
    logic                         m_tvalid_reg;
    logic [hbc_pkg::BUCKET_W-1:0] m_bucket_reg;
    logic [COUNT_BITS-1:0]        m_count_reg;
    logic [COUNT_BITS-1:0]        mem [MAX_BUCKETS];

    logic [EXT_W-1:0]       lower_ext;
    logic [EXT_W-1:0]       upper_ext;
    logic [SAMPLE_BITS-1:0] lower_s;
    logic [SAMPLE_BITS-1:0] upper_s;
    logic [DIF_W-1:0]       range;
    logic [DIF_W-1:0]       diff;
    logic [AW-1:0]          biu_ext;
    logic [AW-1:0]          active_a;
    logic [ACT_W-1:0]       active;
    logic [ACT_W-1:0]       last;
    logic                   div_start;
    logic [DVW-1:0]         div_dividend;
    logic [DVW-1:0]         div_divisor;
    logic                   div_done;
    logic [DVW-1:0]         quotient;
    logic [IDX_W-1:0]       idx;
    logic [SEL_W-1:0]       idx_ext;
    logic [SEL_W-1:0]       sel_ext;
    logic                   sel_ok;
    logic [COUNT_BITS-1:0]  count_inc;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [COUNT_BITS-1:0]  mem_wdata;

    always_comb
    begin
        lower_ext = EXT_W'(lower_reg);
        upper_ext = EXT_W'(upper_reg);
        lower_s   = lower_ext[SAMPLE_BITS-1:0];
        upper_s   = upper_ext[SAMPLE_BITS-1:0];
        range     = {upper_s[SAMPLE_BITS-1], upper_s} - {lower_s[SAMPLE_BITS-1], lower_s};
        diff      = {sample_reg[SAMPLE_BITS-1], sample_reg}
                    - {lower_s[SAMPLE_BITS-1], lower_s};

        biu_ext = AW'(biu_reg);
        if (biu_ext == '0)
            active_a = AW'(1);
        else if (biu_ext > AW'(MAX_BUCKETS))
            active_a = AW'(MAX_BUCKETS);
        else
            active_a = biu_ext;
        active = active_a[ACT_W-1:0];
        last   = active - 1'b1;

        div_start = ctl.width_start || ctl.idx_start;
        if (ctl.width_start)
        begin
            div_dividend = (!range[DIF_W-1] && range != '0) ? DVW'(range[SAMPLE_BITS-1:0]) : '0;
            div_divisor  = DVW'(active);
        end
        else
        begin
            div_dividend = (!diff[DIF_W-1] && diff != '0) ? DVW'(diff[SAMPLE_BITS-1:0]) : '0;
            div_divisor  = DVW'(width_reg);
        end

        idx     = (quotient > DVW'(last)) ? last[IDX_W-1:0] : quotient[IDX_W-1:0];
        idx_ext = SEL_W'(idx);
        sel_ext = SEL_W'(in_select);
        sel_ok  = ({1'b0, sel_ext} < (SEL_W + 1)'(MAX_BUCKETS));

        count_inc = (rdata_reg == '1) ? rdata_reg : rdata_reg + 1'b1;

        mem_we    = ctl.clr_step || ctl.mem_update;
        mem_waddr = ctl.clr_step ? clr_reg : addr_reg;
        mem_wdata = ctl.clr_step ? '0 : count_inc;
    end

    hbc_div #(
        .W (DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg    <= '0;
            upper_reg    <= hbc_pkg::CFG_W'(256);
            biu_reg      <= hbc_pkg::BIU_W'(256);
            width_reg    <= SAMPLE_BITS'(1);
            dirty_reg    <= 1'b0;
            clr_reg      <= '0;
            cmd_reg      <= hbc_pkg::CMD_NOP;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (hbc_pkg::cfg_idx_t'(cfg_index))
                    hbc_pkg::CFG_LOWER:
                    begin
                        lower_reg <= cfg_data;
                        dirty_reg <= 1'b1;
                    end
                    hbc_pkg::CFG_UPPER:
                    begin
                        upper_reg <= cfg_data;
                        dirty_reg <= 1'b1;
                    end
                    hbc_pkg::CFG_BUCKETS:
                    begin
                        biu_reg   <= cfg_data[hbc_pkg::BIU_W-1:0];
                        dirty_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (ctl.width_load)
            begin
                width_reg <= (quotient[SAMPLE_BITS-1:0] == '0) ? SAMPLE_BITS'(1)
                                                               : quotient[SAMPLE_BITS-1:0];
                dirty_reg <= 1'b0;
            end

            if (ctl.clr_start)
                clr_reg <= '0;
            else if (ctl.clr_step)
                clr_reg <= clr_reg + 1'b1;

            if (ctl.accept)
                cmd_reg <= hbc_pkg::cmd_t'(in_cmd);

            if (ctl.out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            sample_reg     <= in_sample;
            sel_ok_reg     <= sel_ok;
            addr_reg       <= sel_ext[IDX_W-1:0];
            res_bucket_reg <= (hbc_pkg::cmd_t'(in_cmd) == hbc_pkg::CMD_READ) ? in_select : '0;
            res_count_reg  <= '0;
        end
        else if (ctl.idx_load)
        begin
            addr_reg       <= idx;
            res_bucket_reg <= idx_ext[hbc_pkg::BUCKET_W-1:0];
        end
        else if (ctl.mem_update)
            res_count_reg <= count_inc;
        else if (ctl.res_read)
            res_count_reg <= sel_ok_reg ? rdata_reg : '0;

        if (ctl.out_load)
        begin
            m_bucket_reg <= res_bucket_reg;
            m_count_reg  <= res_count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (ctl.mem_read)
            rdata_reg <= mem[addr_reg];
    end

    assign m_tvalid   = m_tvalid_reg;
    assign out_bucket = m_bucket_reg;
    assign out_count  = m_count_reg;

    assign sts.in_cmd      = hbc_pkg::cmd_t'(in_cmd);
    assign sts.cmd         = cmd_reg;
    assign sts.width_dirty = dirty_reg;
    assign sts.div_done    = div_done;
    assign sts.clr_last    = (clr_reg == IDX_W'(MAX_BUCKETS - 1));
    assign sts.out_free    = !m_tvalid_reg || m_tready;

endmodule

FILE: src/hbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_ctrl
// Command sequencer: clear sweep, width derivation, binning, memory access
// and result hand-off.
// ----------------------------------------------------------------------------
module hbc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  hbc_pkg::dp_status_t sts,
    output hbc_pkg::dp_cmd_t    ctl
);

    hbc_pkg::state_t state_reg;
    hbc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hbc_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hbc_pkg::ST_CLEAR:
                if (sts.clr_last)
                    state_next = hbc_pkg::ST_IDLE;
            hbc_pkg::ST_IDLE:
                if (s_tvalid)
                begin
                    case (sts.in_cmd)
                        hbc_pkg::CMD_ADD:
                            state_next = sts.width_dirty ? hbc_pkg::ST_WSTART
                                                         : hbc_pkg::ST_ISTART;
                        hbc_pkg::CMD_READ:
                            state_next = hbc_pkg::ST_RRD;
                        default:
                            state_next = hbc_pkg::ST_DONE;
                    endcase
                end
            hbc_pkg::ST_WSTART:
                state_next = hbc_pkg::ST_WWAIT;
            hbc_pkg::ST_WWAIT:
                if (sts.div_done)
                    state_next = hbc_pkg::ST_ISTART;
            hbc_pkg::ST_ISTART:
                state_next = hbc_pkg::ST_IWAIT;
            hbc_pkg::ST_IWAIT:
                if (sts.div_done)
                    state_next = hbc_pkg::ST_ARD;
            hbc_pkg::ST_ARD:
                state_next = hbc_pkg::ST_AUPD;
            hbc_pkg::ST_AUPD:
                state_next = hbc_pkg::ST_DONE;
            hbc_pkg::ST_RRD:
                state_next = hbc_pkg::ST_RDAT;
            hbc_pkg::ST_RDAT:
                state_next = hbc_pkg::ST_DONE;
            hbc_pkg::ST_DONE:
                if (sts.out_free)
                    state_next = (sts.cmd == hbc_pkg::CMD_CLEAR) ? hbc_pkg::ST_CLEAR
                                                                 : hbc_pkg::ST_IDLE;
            default:
                state_next = hbc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        s_tready = 1'b0;
        case (state_reg)
            hbc_pkg::ST_CLEAR:
                ctl.clr_step = 1'b1;
            hbc_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                ctl.accept = s_tvalid;
            end
            hbc_pkg::ST_WSTART:
                ctl.width_start = 1'b1;
            hbc_pkg::ST_WWAIT:
                ctl.width_load = sts.div_done;
            hbc_pkg::ST_ISTART:
                ctl.idx_start = 1'b1;
            hbc_pkg::ST_IWAIT:
                ctl.idx_load = sts.div_done;
            hbc_pkg::ST_ARD:
                ctl.mem_read = 1'b1;
            hbc_pkg::ST_AUPD:
                ctl.mem_update = 1'b1;
            hbc_pkg::ST_RRD:
                ctl.mem_read = 1'b1;
            hbc_pkg::ST_RDAT:
                ctl.res_read = 1'b1;
            hbc_pkg::ST_DONE:
            begin
                ctl.out_load  = sts.out_free;
                ctl.clr_start = sts.out_free && (sts.cmd == hbc_pkg::CMD_CLEAR);
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: src/histogram_bucket_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_bucket_counter
// Uniform-width histogram: bins signed samples into saturating bucket counts.
// ----------------------------------------------------------------------------
// Input beats carry a command on s_tuser (add, read, clear, no-op) with the
// sample and bucket select on s_tdata. Every beat yields one output beat on
// m_tdata: the bucket and its count after the command (0 and 0 for a no-op).
// Configuration writes (lower bound, upper bound, buckets in use) land on
// cfg_we; they mark the bucket width stale and the next add rederives it.
// One item at a time, with one radix-2 divider doing one quotient bit a cycle:
//   add:   rederive the width if stale, then divide the sample offset by the width
//          for the bucket, read its count and write it back incremented
//   read:  read the selected count; clear and no-op go straight to the result
//   clear also starts a sweep of all MAX_BUCKETS counts, one count per cycle.
// Reset clears all counts with that same sweep; s_tready is low until it
// ends. Registers return to 0 / 256 / 256 with bucket width 1.
// The result waits in an output register; while m_tready is low the next
// item may be accepted and worked on, and it waits in its last state until
// the output register frees.
// ----------------------------------------------------------------------------
module histogram_bucket_counter #(
    parameter int MAX_BUCKETS = 256,
    parameter int SAMPLE_BITS = 32,
    parameter int COUNT_BITS  = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [hbc_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [hbc_pkg::CFG_W-1:0]               cfg_data,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // sample, bucket_select
    input  logic [((SAMPLE_BITS+hbc_pkg::BUCKET_W+7)/8)*8-1:0] s_tdata,
    // command
    input  logic [hbc_pkg::CMD_W-1:0]               s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // bucket, count
    output logic [((hbc_pkg::BUCKET_W+COUNT_BITS+7)/8)*8-1:0]  m_tdata
);

    localparam int OUT_W = ((hbc_pkg::BUCKET_W + COUNT_BITS + 7) / 8) * 8;

    hbc_pkg::dp_cmd_t             ctl;
    hbc_pkg::dp_status_t          sts;
    logic [hbc_pkg::BUCKET_W-1:0] out_bucket;
    logic [COUNT_BITS-1:0]        out_count;

    hbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    hbc_datapath #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_cmd     (s_tuser),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .in_select  (s_tdata[SAMPLE_BITS+hbc_pkg::BUCKET_W-1:SAMPLE_BITS]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_bucket (out_bucket),
        .out_count  (out_count),
        .ctl        (ctl),
        .sts        (sts)
    );

    assign m_tdata = OUT_W'({out_count, out_bucket});

endmodule
